FILE: rtl/ptrmx_pkg.sv
// ----------------------------------------------------------------------------
// ptrmx_pkg
// Shared types and codes for the persistent trie range max-xor block.
// ----------------------------------------------------------------------------
package ptrmx_pkg;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // control word handed from one level cell to the next
    typedef struct packed {
        logic vld;
        logic query;
        logic hi_ok;
        logic lo_ok;
    } ctl_t;

endpackage

FILE: rtl/ptrmx_cell.sv
// ----------------------------------------------------------------------------
// ptrmx_cell
// One trie level: node store for this level, one step of insert or search.
// ----------------------------------------------------------------------------
module ptrmx_cell
    import ptrmx_pkg::*;
#(
    parameter int LEVEL = 0,
    parameter int KW    = 26,
    parameter int PW    = 13,
    parameter int CW    = 13,
    parameter int DEPTH = 4097
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  ctl_t          in_ctl,
    input  logic [PW-1:0] in_hi,
    input  logic [PW-1:0] in_lo,
    input  logic [PW-1:0] in_ver,
    input  logic [KW-1:0] in_key,
    input  logic [KW-1:0] in_ans,
    output ctl_t          out_ctl,
    output logic [PW-1:0] out_hi,
    output logic [PW-1:0] out_lo,
    output logic [PW-1:0] out_ver,
    output logic [KW-1:0] out_key,
    output logic [KW-1:0] out_ans
);

    localparam int NW = 2 * PW + 2 * CW;
    // version 0 node: only the left child, holding the zero prefix
    localparam logic [NW-1:0] V0 = {{PW{1'b0}}, {PW{1'b0}}, CW'(1), {CW{1'b0}}};

    logic [NW-1:0] mem [0:DEPTH-1];

    ctl_t          ctl_reg;
    logic          hi_zero_reg;
    logic          lo_zero_reg;
    logic [PW-1:0] ver_reg;
    logic [KW-1:0] key_reg;
    logic [KW-1:0] ans_reg;
    logic [NW-1:0] rd_hi_reg;
    logic [NW-1:0] rd_lo_reg;

    logic [NW-1:0] hi_node;
    logic [NW-1:0] lo_node;
    logic [PW-1:0] h_lptr;
    logic [PW-1:0] h_rptr;
    logic [CW-1:0] h_lcnt;
    logic [CW-1:0] h_rcnt;
    logic [PW-1:0] l_lptr;
    logic [PW-1:0] l_rptr;
    logic [CW-1:0] l_lcnt;
    logic [CW-1:0] l_rcnt;
    logic          bit_v;
    logic          want;
    logic          take;
    logic          side;
    logic [CW-1:0] h_wcnt;
    logic [CW-1:0] l_wcnt;
    logic [CW-1:0] h_scnt;
    logic [CW-1:0] l_scnt;
    logic          we;
    logic [NW-1:0] wd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_zero_reg <= (in_hi == '0);
        lo_zero_reg <= (in_lo == '0);
        ver_reg     <= in_ver;
        key_reg     <= in_key;
        ans_reg     <= in_ans;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[ver_reg] <= wd;
        end
        rd_hi_reg <= mem[in_hi];
        rd_lo_reg <= mem[in_lo];
    end

    always_comb
    begin
        hi_node = !ctl_reg.hi_ok ? '0 : (hi_zero_reg ? V0 : rd_hi_reg);
        lo_node = !ctl_reg.lo_ok ? '0 : (lo_zero_reg ? V0 : rd_lo_reg);
        h_lptr  = hi_node[NW-1 -: PW];
        h_rptr  = hi_node[NW-PW-1 -: PW];
        h_lcnt  = hi_node[2*CW-1 -: CW];
        h_rcnt  = hi_node[CW-1:0];
        l_lptr  = lo_node[NW-1 -: PW];
        l_rptr  = lo_node[NW-PW-1 -: PW];
        l_lcnt  = lo_node[2*CW-1 -: CW];
        l_rcnt  = lo_node[CW-1:0];
        bit_v   = key_reg[LEVEL];
        want    = ~bit_v;
        h_wcnt  = want ? h_rcnt : h_lcnt;
        l_wcnt  = want ? l_rcnt : l_lcnt;
        take    = ctl_reg.query && (h_wcnt > l_wcnt);
        side    = take ? want : bit_v;
        h_scnt  = side ? h_rcnt : h_lcnt;
        l_scnt  = side ? l_rcnt : l_lcnt;

        out_ctl.vld   = ctl_reg.vld;
        out_ctl.query = ctl_reg.query;
        out_ctl.hi_ok = (h_scnt != '0);
        out_ctl.lo_ok = (l_scnt != '0);
        out_hi        = side ? h_rptr : h_lptr;
        out_lo        = side ? l_rptr : l_lptr;
        out_ver       = ver_reg;
        out_key       = key_reg;
        out_ans       = ans_reg;
        out_ans[LEVEL] = take;

        // path copy: new node points at the next level node of the same version
        we = ctl_reg.vld && !ctl_reg.query;
        if (bit_v)
        begin
            wd = {h_lptr, ver_reg, h_lcnt, h_rcnt + CW'(1)};
        end
        else
        begin
            wd = {ver_reg, h_rptr, h_lcnt + CW'(1), h_rcnt};
        end
    end

endmodule

FILE: rtl/persistent_trie_range_max_xor.sv
// ----------------------------------------------------------------------------
// persistent_trie_range_max_xor
// Append values and answer range max-xor queries over their prefix xors.
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries action, value, left_pos, right_pos
//   output channel out_valid/out_ready carries max_xor and status
//   one word in flight: in_ready is high only while the block is idle
//   append or query: a launch register, then KEY_BITS level cells in a chain;
//   the result register loads from the last level cell as out_valid is raised
//   store full or bad range answers in the cycle after accept
//   the chain of level cells, each with its own node store, sets latency
//   a stalled receiver holds the result; no new word is taken until it leaves
//   reset empties the sequence; the zero prefix trie is built into the cells,
//   so no clearing pass runs and the block is ready right after reset
// ----------------------------------------------------------------------------
module persistent_trie_range_max_xor
    import ptrmx_pkg::*;
#(
    parameter int MAX_LEN  = 4096,
    parameter int KEY_BITS = 26
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [25:0] value,
    input  logic [12:0] left_pos,
    input  logic [12:0] right_pos,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [25:0] max_xor,
    output logic [1:0]  status
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(MAX_LEN + 2);
    localparam int KW = KEY_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [PW-1:0] seq_len_reg;
    logic [KW-1:0] run_xor_reg;
    ctl_t          l_ctl_reg;
    ctl_t          l_ctl_next;
    logic [PW-1:0] l_hi_reg;
    logic [PW-1:0] l_lo_reg;
    logic [PW-1:0] l_ver_reg;
    logic [KW-1:0] l_key_reg;
    logic [25:0]   max_xor_reg;
    logic [1:0]    status_reg;

    logic          acc;
    logic          is_q;
    logic          full;
    logic          bad;
    logic          launch;
    logic [KW-1:0] val_k;
    logic [KW-1:0] key_new;

    ctl_t          c_ctl [0:KEY_BITS];
    logic [PW-1:0] c_hi  [0:KEY_BITS];
    logic [PW-1:0] c_lo  [0:KEY_BITS];
    logic [PW-1:0] c_ver [0:KEY_BITS];
    logic [KW-1:0] c_key [0:KEY_BITS];
    logic [KW-1:0] c_ans [0:KEY_BITS];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign max_xor   = max_xor_reg;
    assign status    = status_reg;

    always_comb
    begin
        acc     = in_valid && in_ready;
        is_q    = (action == ACT_QUERY);
        val_k   = KW'(value);
        key_new = run_xor_reg ^ val_k;
        full    = (seq_len_reg == PW'(MAX_LEN));
        bad     = (left_pos == '0) || (right_pos == '0) || (left_pos > right_pos)
                  || (32'(right_pos) > 32'(seq_len_reg));
        launch  = acc && (is_q ? !bad : !full);

        l_ctl_next.vld   = launch;
        l_ctl_next.query = is_q;
        l_ctl_next.hi_ok = 1'b1;
        l_ctl_next.lo_ok = is_q && (left_pos >= 13'd2);

        unique case (state_reg)
            S_IDLE: state_next = acc ? (launch ? S_RUN : S_DONE) : S_IDLE;
            S_RUN:  state_next = c_ctl[KEY_BITS].vld ? S_DONE : S_RUN;
            S_DONE: state_next = out_ready ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            seq_len_reg <= '0;
            run_xor_reg <= '0;
            l_ctl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            l_ctl_reg <= l_ctl_next;
            if (launch && !is_q)
            begin
                seq_len_reg <= seq_len_reg + PW'(1);
                run_xor_reg <= key_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            l_hi_reg  <= is_q ? PW'(right_pos - 13'd1) : seq_len_reg;
            l_lo_reg  <= PW'(left_pos - 13'd2);
            l_ver_reg <= seq_len_reg + PW'(1);
            l_key_reg <= key_new;
        end
        if (acc && !launch)
        begin
            max_xor_reg <= '0;
            status_reg  <= is_q ? ST_RANGE : ST_FULL;
        end
        else if (state_reg == S_RUN && c_ctl[KEY_BITS].vld)
        begin
            max_xor_reg <= 26'(c_ans[KEY_BITS]);
            status_reg  <= ST_OK;
        end
    end

    assign c_ctl[0] = l_ctl_reg;
    assign c_hi[0]  = l_hi_reg;
    assign c_lo[0]  = l_lo_reg;
    assign c_ver[0] = l_ver_reg;
    assign c_key[0] = l_key_reg;
    assign c_ans[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < KEY_BITS; gi++)
        begin : g_level
            ptrmx_cell #(
                .LEVEL (KEY_BITS - 1 - gi),
                .KW    (KW),
                .PW    (PW),
                .CW    (CW),
                .DEPTH (MAX_LEN + 1)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .in_ctl  (c_ctl[gi]),
                .in_hi   (c_hi[gi]),
                .in_lo   (c_lo[gi]),
                .in_ver  (c_ver[gi]),
                .in_key  (c_key[gi]),
                .in_ans  (c_ans[gi]),
                .out_ctl (c_ctl[gi+1]),
                .out_hi  (c_hi[gi+1]),
                .out_lo  (c_lo[gi+1]),
                .out_ver (c_ver[gi+1]),
                .out_key (c_key[gi+1]),
                .out_ans (c_ans[gi+1])
            );
        end
    endgenerate

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("word accepted while busy");

    a_chain_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        c_ctl[KEY_BITS].vld |-> (state_reg == S_RUN))
        else $error("chain output outside run state");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (max_xor == '0))
        else $error("error result with nonzero answer");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (launch && !is_q) |-> (seq_len_reg < PW'(MAX_LEN)))
        else $error("append launched on full store");
`endif

endmodule

FILE: tb/ptrmx_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptrmx_scoreboard
// Watches both channels of the range max-xor block, keeps its own prefix
// trie of the sequence, predicts every answer and compares it in order.
// ----------------------------------------------------------------------------
module ptrmx_scoreboard
    import ptrmx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        action,
    input  logic [25:0] value,
    input  logic [12:0] left_pos,
    input  logic [12:0] right_pos,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [25:0] max_xor,
    input  logic [1:0]  status,
    output int          errors,
    output int          outstanding
);

    localparam int SEQ_MAX = 4096;
    localparam int KBITS   = 26;
    localparam int POOL    = (SEQ_MAX + 1) * (KBITS + 1) + 1;

    typedef struct packed {
        logic [25:0] max_xor;
        logic [1:0]  status;
    } answer_t;

    int unsigned lch [POOL];
    int unsigned rch [POOL];
    int unsigned cnt [POOL];
    int unsigned vroot [SEQ_MAX + 1];
    int unsigned nodes_used;
    logic [25:0] prefix_acc;
    int unsigned seq_len;
    answer_t     answers_due[$];

    function automatic int unsigned add_prefix(int unsigned old_root, logic [25:0] key);
        int unsigned fresh;
        int unsigned cur;
        int unsigned prev;
        int unsigned nxt;
        fresh = nodes_used + 1;
        nodes_used = fresh;
        cur = fresh;
        prev = old_root;
        for (int b = KBITS - 1; b >= 0; b--)
        begin
            nxt = nodes_used + 1;
            lch[cur] = lch[prev];
            rch[cur] = rch[prev];
            cnt[cur] = cnt[prev] + 1;
            prev = key[b] ? rch[prev] : lch[prev];
            nodes_used = nxt;
            if (key[b])
                rch[cur] = nxt;
            else
                lch[cur] = nxt;
            cur = nxt;
        end
        lch[cur] = 0;
        rch[cur] = 0;
        cnt[cur] = cnt[prev] + 1;
        return fresh;
    endfunction

    function automatic logic [25:0] best_xor(int unsigned lo, int unsigned hi, logic [25:0] key);
        logic [25:0] ans;
        int unsigned hc;
        int unsigned lc;
        ans = '0;
        for (int b = KBITS - 1; b >= 0; b--)
        begin
            hc = key[b] ? lch[hi] : rch[hi];
            lc = key[b] ? lch[lo] : rch[lo];
            if (cnt[hc] > cnt[lc])
            begin
                hi = hc;
                lo = lc;
                ans[b] = 1'b1;
            end
            else
            begin
                hi = key[b] ? rch[hi] : lch[hi];
                lo = key[b] ? rch[lo] : lch[lo];
            end
        end
        return ans;
    endfunction

    function automatic answer_t predict_answer(logic act, logic [25:0] v,
                                               int unsigned l, int unsigned r);
        answer_t a;
        int unsigned lo;
        a = '{max_xor: '0, status: ST_OK};
        if (act == ACT_APPEND)
        begin
            if (seq_len >= SEQ_MAX)
                a.status = ST_FULL;
            else
            begin
                prefix_acc = prefix_acc ^ v;
                seq_len++;
                vroot[seq_len] = add_prefix(vroot[seq_len - 1], prefix_acc);
            end
        end
        else if (l == 0 || r == 0 || l > r || r > seq_len)
            a.status = ST_RANGE;
        else
        begin
            lo = (l >= 2) ? vroot[l - 2] : 0;
            a.max_xor = best_xor(lo, vroot[r - 1], prefix_acc ^ v);
        end
        return a;
    endfunction

    initial
    begin
        errors = 0;
        nodes_used = 0;
        prefix_acc = '0;
        seq_len = 0;
        vroot[0] = add_prefix(0, '0);
    end

    assign outstanding = answers_due.size();

    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && in_valid && in_ready)
            answers_due.push_back(predict_answer(action, value, left_pos, right_pos));
        if (rst_n && out_valid && out_ready)
        begin
            if (answers_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: max_xor %0d status %0d", max_xor, status);
            end
            else
            begin
                e = answers_due.pop_front();
                if (e.max_xor !== max_xor || e.status !== status)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp max_xor %0d status %0d, got %0d %0d",
                                 e.max_xor, e.status, max_xor, status);
                end
            end
        end
    end

endmodule

FILE: tb/tb_persistent_trie_range_max_xor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_persistent_trie_range_max_xor
// Drives appends and range queries with random gaps on both channels, probes
// bad ranges at the top of the position space, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_persistent_trie_range_max_xor;
    import ptrmx_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [25:0] value;
    logic [12:0] left_pos;
    logic [12:0] right_pos;
    logic        out_valid;
    logic        out_ready;
    logic [25:0] max_xor;
    logic [1:0]  status;
    int          errors;
    int          outstanding;
    int          seq_len;
    int          cycle_cnt;

    persistent_trie_range_max_xor i_dut (.*);

    ptrmx_scoreboard i_scoreboard (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 19);
        if (p < 12)
            return 0;
        if (p < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [25:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 26'(1) << $urandom_range(0, 25);
            default: return 26'($urandom());
        endcase
    endfunction

    task automatic send_word(logic act, logic [25:0] v, logic [12:0] l, logic [12:0] r);
        int g;
        in_valid  <= 1'b1;
        action    <= act;
        value     <= v;
        left_pos  <= l;
        right_pos <= r;
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
        if (act == ACT_APPEND && seq_len < 4096)
            seq_len++;
        g = pick_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_query_in_range();
        int r;
        int l;
        r = $urandom_range(1, seq_len);
        l = ($urandom_range(0, 3) == 0) ? $urandom_range(1, r) :
                                          $urandom_range((r > 8) ? r - 8 : 1, r);
        send_word(ACT_QUERY, pick_value(), 13'(l), 13'(r));
    endtask

    // receiver: random stalls, one long hold-off while input keeps coming
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            cycle_cnt <= 0;
        end
        else
        begin
            cycle_cnt <= cycle_cnt + 1;
            if (cycle_cnt >= 3000 && cycle_cnt < 3600)
                out_ready <= 1'b0;
            else if (cycle_cnt[9])
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 9) < 7);
        end
    end

    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        in_valid  = 1'b0;
        action    = ACT_APPEND;
        value     = '0;
        left_pos  = '0;
        right_pos = '0;
        seq_len   = 0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_word(ACT_QUERY, '0, 13'd1, 13'd1);
        send_word(ACT_APPEND, '0, '1, '1);
        send_word(ACT_QUERY, '0, 13'd1, 13'd1);
        send_word(ACT_QUERY, '1, 13'd1, 13'd1);
        send_word(ACT_APPEND, '1, '0, '0);
        send_word(ACT_APPEND, 26'h2AAAAAA, '0, '0);
        send_word(ACT_APPEND, 26'h1555555, '0, '0);
        send_word(ACT_QUERY, '0, 13'd1, 13'd4);
        send_word(ACT_QUERY, '1, 13'd2, 13'd3);
        send_word(ACT_QUERY, 26'h1555555, 13'd4, 13'd4);
        send_word(ACT_QUERY, '0, 13'd0, 13'd2);
        send_word(ACT_QUERY, '0, 13'd1, 13'd0);
        send_word(ACT_QUERY, '0, 13'd0, 13'd0);
        send_word(ACT_QUERY, '0, 13'd3, 13'd2);
        send_word(ACT_QUERY, '0, 13'd1, 13'd5);
        send_word(ACT_QUERY, '0, '1, '1);
        send_word(ACT_QUERY, '0, 13'd4096, 13'd4096);

        // random mix
        repeat (1300)
        begin
            case ($urandom_range(0, 19))
                0, 1:
                    send_word(ACT_QUERY, pick_value(), 13'($urandom()), 13'($urandom()));
                2, 3, 4, 5, 6, 7, 8, 9, 10:
                    send_word(ACT_APPEND, pick_value(), 13'($urandom()), 13'($urandom()));
                default:
                    if (seq_len > 0)
                        send_query_in_range();
                    else
                        send_word(ACT_QUERY, pick_value(), 13'd1, 13'd1);
            endcase
        end

        send_word(ACT_APPEND, '1, '0, '0);
        send_word(ACT_APPEND, pick_value(), '1, '1);
        send_word(ACT_QUERY, '0, 13'd1, 13'd4096);
        send_word(ACT_QUERY, '1, 13'd4096, 13'd4096);
        send_word(ACT_QUERY, '0, 13'd4097, 13'd4097);
        send_word(ACT_QUERY, '0, 13'd1, '1);
        repeat (30)
            send_query_in_range();

        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
